/* rtl/ccd_pkg.sv */
// Package: shared types, constants and codes for the column update engine
`timescale 1ns / 1ps
package ccd_pkg;

  localparam int FracBits = 16;
  localparam int MaxColumnEntries = 65536;
  localparam int CountW = 17;
  localparam logic [31:0] LambdaReset = 32'd6554;
  localparam logic [62:0] U63Max = {63{1'b1}};

  typedef enum logic [1:0] {
    CMD_RANK_ONE  = 2'd0,
    CMD_RES_ADD   = 2'd1,
    CMD_RES_SUB   = 2'd2,
    CMD_EMPTY_COL = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] residual;
    logic signed [31:0] factor_row;
    logic signed [31:0] factor_col;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [62:0]        column_loss;
    logic               result_kind;
    logic               end_of_column;
  } result_t;

endpackage

/* rtl/ccd_fifo.sv */
// Two-entry item queue between front and back
`timescale 1ns / 1ps
module ccd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  ccd_pkg::item_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output ccd_pkg::item_t rd_data_o,
  output logic           empty_o
);
  import ccd_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o    = cnt_q == 2'd2;
  assign empty_o   = cnt_q == 2'd0;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i && !full_o) wp_q <= ~wp_q;
      if (rd_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr_i && !full_o) - 2'(rd_i && !empty_o);
    end
  end
endmodule

/* rtl/ccd_divider.sv */
// Restoring divider: 64-bit magnitude by 63-bit divisor, FracBits extra bits
`timescale 1ns / 1ps
module ccd_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [62:0]        den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o
);
  import ccd_pkg::*;

  localparam int Steps = 64 + FracBits;
  localparam int StepW = $clog2(Steps + 1);

  logic [Steps-1:0] a_q, q_q;
  logic [63:0]      r_q;
  logic [62:0]      d_q;
  logic             neg_q, busy_q, zero_q;
  logic [StepW-1:0] n_q;
  logic [64:0]      r_sh;
  logic             ge;

  assign r_sh = {r_q, a_q[Steps-1]};
  assign ge   = r_sh >= {2'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      n_q    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        n_q    <= StepW'(Steps);
      end else if (busy_q) begin
        n_q <= n_q - 1'b1;
        if (n_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= num_i[63];
      a_q    <= {(num_i[63] ? 64'(-num_i) : 64'(num_i)), {FracBits{1'b0}}};
      q_q    <= '0;
      r_q    <= '0;
      d_q    <= den_i;
      zero_q <= den_i == '0;
    end else if (busy_q) begin
      a_q <= a_q << 1;
      q_q <= {q_q[Steps-2:0], ge};
      r_q <= ge ? 64'(r_sh - {2'b0, d_q}) : r_sh[63:0];
    end
  end

  always_comb begin
    if (zero_q) quot_o = '0;
    else if (neg_q) quot_o = (q_q >= Steps'(33'h80000000)) ? 32'sh80000000 : 32'(-q_q);
    else quot_o = (q_q >= Steps'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : 32'(q_q);
  end
endmodule

/* rtl/ccd_back.sv */
// Back end: accumulation, residual update, coefficient division, result register
`timescale 1ns / 1ps
module ccd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [31:0]      lambda_i,
  input  logic             item_valid_i,
  input  ccd_pkg::item_t   item_i,
  output logic             item_take_o,
  output logic             res_valid_o,
  output ccd_pkg::result_t res_o,
  input  logic             res_take_i
);
  import ccd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_REG, S_DEN, S_DIV, S_OUT
  } state_e;

  state_e             state_q;
  item_t              it_q;
  result_t            pend_q;
  logic signed [63:0] p1_q, p2_q;
  logic signed [63:0] g_q;
  logic [62:0]        h_q, loss_q, den;
  logic [CountW-1:0]  cnt_q;
  logic [48:0]        reg_q;
  logic               div_start, div_done;
  logic signed [31:0] quot;

  logic signed [64:0] g_sum;
  logic [63:0]        h_sum, l_sum, d_sum;
  logic signed [64:0] nv_wide;
  logic signed [31:0] nv;
  logic signed [63:0] prod_sh;
  logic [62:0]        reg_sh;

  assign item_take_o = state_q == S_IDLE && item_valid_i;
  assign div_start   = state_q == S_DEN && it_q.cmd == CMD_RANK_ONE;
  assign prod_sh     = p1_q >>> FracBits;
  assign g_sum       = 65'(g_q) + 65'(p1_q);
  assign h_sum       = {1'b0, h_q} + 64'(p2_q);
  assign nv_wide     = (it_q.cmd == CMD_RES_ADD) ? 65'(it_q.residual) + 65'(prod_sh)
                                                 : 65'(it_q.residual) - 65'(prod_sh);
  assign nv = (nv_wide > 65'sd2147483647) ? 32'sh7FFFFFFF :
              (nv_wide < -65'sd2147483648) ? 32'sh80000000 : 32'(nv_wide);
  assign l_sum  = {1'b0, loss_q} + 64'(p2_q);
  assign reg_sh = (reg_q > 49'(U63Max >> FracBits)) ? U63Max : 63'({reg_q, {FracBits{1'b0}}});
  assign d_sum  = {1'b0, h_q} + {1'b0, reg_sh};
  assign den    = d_sum[63] ? U63Max : d_sum[62:0];

  ccd_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(g_q), .den_i(den),
    .done_o(div_done), .quot_o(quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_o <= 1'b0;
      g_q <= '0; h_q <= '0; loss_q <= '0; cnt_q <= '0;
    end else begin
      if (state_q == S_OUT && (!res_valid_o || res_take_i)) res_valid_o <= 1'b1;
      else if (res_take_i) res_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: if (item_valid_i) begin
          it_q <= item_i;
          if (item_i.cmd == CMD_EMPTY_COL) begin
            pend_q <= '{result_value: '0, column_loss: '0, result_kind: 1'b1,
                        end_of_column: 1'b1};
            g_q <= '0; h_q <= '0; loss_q <= '0; cnt_q <= '0;
            state_q <= S_OUT;
          end else state_q <= S_MUL;
        end
        S_MUL: begin
          if (it_q.cmd == CMD_RANK_ONE) begin
            p1_q <= 64'(it_q.factor_row * it_q.residual);
            p2_q <= 64'(it_q.factor_row * it_q.factor_row);
          end else p1_q <= 64'(it_q.factor_row * it_q.factor_col);
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (it_q.cmd == CMD_RANK_ONE) begin
            g_q <= (g_sum > 65'sh7FFFFFFFFFFFFFFF) ? 64'sh7FFFFFFFFFFFFFFF :
                   (g_sum < -65'sh8000000000000000) ? 64'sh8000000000000000 : 64'(g_sum);
            h_q <= h_sum[63] ? U63Max : h_sum[62:0];
            if (cnt_q < CountW'(MaxColumnEntries)) cnt_q <= cnt_q + 1'b1;
            state_q <= it_q.last ? S_REG : S_IDLE;
          end else begin
            p2_q    <= 64'(nv * nv);
            pend_q  <= '{result_value: nv, column_loss: '0, result_kind: 1'b0,
                         end_of_column: it_q.last};
            state_q <= S_DEN;
          end
        end
        S_REG: begin
          reg_q   <= 49'(lambda_i * cnt_q);
          state_q <= S_DEN;
        end
        S_DEN: begin
          if (it_q.cmd == CMD_RANK_ONE) begin
            state_q <= S_DIV;
          end else begin
            if (it_q.last) begin
              pend_q.column_loss <= l_sum[63] ? U63Max : l_sum[62:0];
              g_q <= '0; h_q <= '0; loss_q <= '0; cnt_q <= '0;
            end else loss_q <= l_sum[63] ? U63Max : l_sum[62:0];
            state_q <= S_OUT;
          end
        end
        S_DIV: if (div_done) begin
          pend_q <= '{result_value: quot, column_loss: '0, result_kind: 1'b1,
                      end_of_column: 1'b1};
          g_q <= '0; h_q <= '0; loss_q <= '0; cnt_q <= '0;
          state_q <= S_OUT;
        end
        S_OUT: if (!res_valid_o || res_take_i) begin
          res_o   <= pend_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/ccd_column_update_engine.sv */
// Top level: column update engine with queue interfaces
//  channel | handshake        | beat
//  in      | push / full      | cmd, residual, factor_row, factor_col, last
//  out     | pop / empty      | result_value, column_loss, result_kind, end_of_column
//  cfg     | lambda_we_i      | lambda_reg
// The back end handles rank-one entries, empty columns and residual entries; a rank-one
// column end also runs the shift-subtract divider.
// Reset clears the accumulators and sets lambda to its default.
// A two-beat queue decouples accepts from the back end; the back end holds in its last
// cycle while the result register still holds a beat that has not been popped.
`timescale 1ns / 1ps
module ccd_column_update_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               lambda_we_i,
  input  logic [31:0]        lambda_reg_i,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] residual_i,
  input  logic signed [31:0] factor_row_i,
  input  logic signed [31:0] factor_col_i,
  input  logic               last_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] result_value_o,
  output logic [62:0]        column_loss_o,
  output logic               result_kind_o,
  output logic               end_of_column_o
);
  import ccd_pkg::*;

  logic [31:0] lambda_q;
  item_t       in_item, q_item;
  logic        q_empty, take, rv;
  result_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lambda_q <= LambdaReset;
    else if (lambda_we_i) lambda_q <= lambda_reg_i;
  end

  assign in_item = '{cmd: cmd_i, residual: residual_i, factor_row: factor_row_i,
                     factor_col: factor_col_i, last: last_i};

  ccd_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(push), .wr_data_i(in_item), .full_o(full),
    .rd_i(take), .rd_data_o(q_item), .empty_o(q_empty)
  );

  ccd_back u_back (
    .clk_i, .rst_ni, .lambda_i(lambda_q),
    .item_valid_i(!q_empty), .item_i(q_item), .item_take_o(take),
    .res_valid_o(rv), .res_o(res), .res_take_i(pop)
  );

  assign empty           = !rv;
  assign result_value_o  = res.result_value;
  assign column_loss_o   = res.column_loss;
  assign result_kind_o   = res.result_kind;
  assign end_of_column_o = res.end_of_column;
endmodule

/* bench/tb_ccd_column_update_engine.sv */
// Testbench: column update engine checked beat by beat against a fixed-point predictor
`timescale 1ns / 1ps
module tb_ccd_column_update_engine;
  import ccd_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 150;
  localparam longint S64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64Min = 64'sh8000_0000_0000_0000;

  class column_scoreboard;
    result_t             expected_q[$];
    logic [31:0]         lambda;
    logic signed [63:0]  g_acc;
    logic [63:0]         h_acc;
    int unsigned         count;
    logic [63:0]         loss_acc;
    int                  errors;
    int                  results_seen;
    int                  coef_seen;

    function new();
      lambda = LambdaReset;
      clear();
      errors = 0;
      results_seen = 0;
      coef_seen = 0;
    endfunction

    function void clear();
      g_acc = '0;
      h_acc = '0;
      count = 0;
      loss_acc = '0;
    endfunction

    function logic signed [63:0] sat_s64(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = a + b;
      if (s > S64Max) return S64Max;
      if (s < S64Min) return S64Min;
      return s[63:0];
    endfunction

    function logic [63:0] sat_u63(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (a > {1'b0, U63Max} || s > {2'b0, U63Max}) return {1'b0, U63Max};
      return s[63:0];
    endfunction

    function logic [31:0] divide_coef(logic signed [63:0] g, logic [63:0] d);
      logic        neg;
      logic [63:0] a, qi, r, q;
      if (d == 0) return '0;
      neg = g < 0;
      a = neg ? 64'd0 - g : g;
      qi = a / d;
      r = a % d;
      if (qi > (64'h8000_0000 >> FracBits)) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      q = qi;
      for (int i = 0; i < FracBits; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q[0] = 1'b1;
        end
      end
      if (neg) return q >= 64'h8000_0000 ? 32'h8000_0000 : 32'd0 - q[31:0];
      return q >= 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function void note_input(item_t it);
      cmd_e               c;
      result_t            r;
      logic signed [63:0] prod, nv;
      logic [63:0]        rw, d;
      c = cmd_e'(it.cmd);
      r = '0;
      case (c)
        CMD_EMPTY_COL: begin
          r.result_kind = 1'b1;
          r.end_of_column = 1'b1;
          clear();
          expected_q.push_back(r);
        end
        CMD_RANK_ONE: begin
          prod = it.factor_row * it.residual;
          g_acc = sat_s64(g_acc, prod);
          prod = it.factor_row * it.factor_row;
          h_acc = sat_u63(h_acc, prod);
          if (count < MaxColumnEntries) count++;
          if (it.last) begin
            rw = {32'd0, lambda} * 64'(count);
            if (rw > ({1'b0, U63Max} >> FracBits)) rw = {1'b0, U63Max};
            else rw = rw << FracBits;
            d = sat_u63(h_acc, rw);
            r.result_value = divide_coef(g_acc, d);
            r.result_kind = 1'b1;
            r.end_of_column = 1'b1;
            clear();
            expected_q.push_back(r);
          end
        end
        default: begin
          prod = (it.factor_row * it.factor_col) >>> FracBits;
          nv = (c == CMD_RES_ADD) ? it.residual + prod : it.residual - prod;
          if (nv > 64'sd2147483647) nv = 64'sd2147483647;
          if (nv < -64'sd2147483648) nv = -64'sd2147483648;
          loss_acc = sat_u63(loss_acc, nv * nv);
          r.result_value = nv[31:0];
          if (it.last) begin
            r.column_loss = loss_acc[62:0];
            r.end_of_column = 1'b1;
            clear();
          end
          expected_q.push_back(r);
        end
      endcase
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
      $display("MISMATCH beat %0d: %s got %h expected %h", results_seen, what, got, exp);
      errors++;
    endtask

    task check_result(result_t got);
      result_t exp;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat, value", got.result_value, 0);
        return;
      end
      exp = expected_q.pop_front();
      if (exp.result_kind) coef_seen++;
      if (got.result_value !== exp.result_value)
        report_mismatch("result_value", got.result_value, exp.result_value);
      if (got.column_loss !== exp.column_loss)
        report_mismatch("column_loss", got.column_loss, exp.column_loss);
      if (got.result_kind !== exp.result_kind)
        report_mismatch("result_kind", got.result_kind, exp.result_kind);
      if (got.end_of_column !== exp.end_of_column)
        report_mismatch("end_of_column", got.end_of_column, exp.end_of_column);
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               lambda_we_i;
  logic [31:0]        lambda_reg_i;
  logic               push;
  logic               full;
  logic [1:0]         cmd_i;
  logic signed [31:0] residual_i;
  logic signed [31:0] factor_row_i;
  logic signed [31:0] factor_col_i;
  logic               last_i;
  logic               empty;
  logic               pop;
  logic signed [31:0] result_value_o;
  logic [62:0]        column_loss_o;
  logic               result_kind_o;
  logic               end_of_column_o;

  column_scoreboard sb;
  int               items_sent;
  int               burst_left;
  int               gap_max;
  int               idle_cycles;
  int               settings_used;

  ccd_column_update_engine DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .lambda_we_i     (lambda_we_i),
    .lambda_reg_i    (lambda_reg_i),
    .push            (push),
    .full            (full),
    .cmd_i           (cmd_i),
    .residual_i      (residual_i),
    .factor_row_i    (factor_row_i),
    .factor_col_i    (factor_col_i),
    .last_i          (last_i),
    .empty           (empty),
    .pop             (pop),
    .result_value_o  (result_value_o),
    .column_loss_o   (column_loss_o),
    .result_kind_o   (result_kind_o),
    .end_of_column_o (end_of_column_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic item_t mk(cmd_e c, logic [31:0] res, logic [31:0] fr,
                               logic [31:0] fc, logic l);
    item_t it;
    it.cmd = c;
    it.residual = res;
    it.factor_row = fr;
    it.factor_col = fc;
    it.last = l;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    int sel;
    sel = $urandom_range(0, 5);
    case (sel)
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0000_0000;
          4: return 32'h0000_0001;
          default: return 32'h0001_0000;
        endcase
      end
      default: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
    endcase
  endfunction

  task automatic send(item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    push <= 1'b1;
    cmd_i <= it.cmd;
    residual_i <= it.residual;
    factor_row_i <= it.factor_row;
    factor_col_i <= it.factor_col;
    last_i <= it.last;
    do @(posedge clk_i); while (full);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_lambda(logic [31:0] v);
    lambda_we_i <= 1'b1;
    lambda_reg_i <= v;
    @(posedge clk_i);
    lambda_we_i <= 1'b0;
    sb.lambda = v;
    settings_used++;
  endtask

  task automatic rand_column();
    int   len, kind;
    cmd_e c;
    item_t it;
    kind = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    if (kind < 45) c = CMD_RANK_ONE;
    else if (kind < 65) c = CMD_RES_ADD;
    else if (kind < 85) c = CMD_RES_SUB;
    else begin
      send(mk(cmd_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
              $urandom_range(0, 1)));
      return;
    end
    for (int i = 0; i < len; i++) begin
      it = mk(c, rand_value(), rand_value(), rand_value(), i == len - 1);
      if ($urandom_range(0, 19) == 0) it.cmd = 2'($urandom_range(0, 2));
      send(it);
    end
  endtask

  task automatic run_random(int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      rand_column();
    end
  endtask

  task automatic directed();
    send(mk(CMD_RANK_ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
    send(mk(CMD_RANK_ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1));
    send(mk(CMD_RANK_ONE, 32'h8000_0000, 32'h8000_0000, 0, 0));
    send(mk(CMD_RANK_ONE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1));
    send(mk(CMD_RANK_ONE, 32'h0001_0000, 32'h0001_0000, 0, 1));
    send(mk(CMD_RANK_ONE, 32'hFFFE_0000, 32'h0000_8000, 0, 1));
    send(mk(CMD_RES_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    send(mk(CMD_RES_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1));
    send(mk(CMD_RES_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    send(mk(CMD_RES_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 0));
    send(mk(CMD_RES_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1));
    send(mk(CMD_EMPTY_COL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    send(mk(CMD_EMPTY_COL, 0, 0, 0, 1));
    send(mk(CMD_RANK_ONE, 32'h0002_0000, 32'h0003_0000, 0, 0));
    send(mk(CMD_EMPTY_COL, 0, 0, 0, 0));
    send(mk(CMD_RES_SUB, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0));
    send(mk(CMD_RANK_ONE, 32'h0001_0000, 32'h0001_0000, 0, 1));
    send(mk(CMD_RES_ADD, 32'h7FFF_FFFF, 0, 0, 0));
    send(mk(CMD_RES_ADD, 32'h7FFF_FFFF, 0, 0, 0));
    send(mk(CMD_RES_SUB, 32'h8000_0000, 0, 0, 1));
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    push = 1'b0;
    lambda_we_i = 1'b0;
    lambda_reg_i = '0;
    cmd_i = '0;
    residual_i = '0;
    factor_row_i = '0;
    factor_col_i = '0;
    last_i = 1'b0;
    items_sent = 0;
    burst_left = 0;
    gap_max = 4;
    settings_used = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    run_random(100);
    drain();
    write_lambda(32'd0);
    send(mk(CMD_RANK_ONE, 32'h0001_0000, 32'h0000_0000, 0, 1));
    send(mk(CMD_RANK_ONE, 32'h8000_0000, 32'h0000_0000, 0, 0));
    send(mk(CMD_RANK_ONE, 32'h0003_0000, 32'h0001_0000, 0, 1));
    run_random(120);
    drain();
    write_lambda(32'hFFFF_FFFF);
    run_random(120);
    drain();
    write_lambda(32'h0001_0000);
    run_random(120);
    drain();
    write_lambda($urandom);
    run_random(60);
    drain();
    write_lambda(LambdaReset);
    run_random(60);
    drain();
    $display("Sent %0d items under %0d lambda settings; checked %0d beats, %0d coefficients",
             items_sent, settings_used, sb.results_seen, sb.coef_seen);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int phase_left, stall_pct;
    pop = 1'b0;
    @(posedge rst_ni);
    for (int i = 0; i < HoldCycles; i++) @(posedge clk_i);
    phase_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty)
        sb.check_result('{result_value_o, column_loss_o, result_kind_o, end_of_column_o});
      if (phase_left == 0) begin
        phase_left = $urandom_range(16, 96);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end
      phase_left--;
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d cycles without a beat", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule
